[rtl/dmwsc_pkg.sv]
// Shared types and codes for the direct-mapped write-back sector cache directory.
package dmwsc_pkg;

	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_META    = 3'd2;
	localparam logic [2:0] OP_FLUSH   = 3'd3;
	localparam logic [2:0] OP_DISCARD = 3'd4;

	localparam logic [1:0] KIND_LOC  = 2'd0;
	localparam logic [1:0] KIND_WB   = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [1:0] ADDR_SLOT = 2'd0;
	localparam logic [1:0] ADDR_PTR  = 2'd1;
	localparam logic [1:0] ADDR_CNT  = 2'd2;

	localparam logic [1:0] WR_ACCESS  = 2'd0;
	localparam logic [1:0] WR_FLUSH   = 2'd1;
	localparam logic [1:0] WR_DISCARD = 2'd2;
	localparam logic [1:0] WR_ZERO    = 2'd3;

	localparam logic [2:0] OUT_LOC        = 3'd0;
	localparam logic [2:0] OUT_VICTIM     = 3'd1;
	localparam logic [2:0] OUT_FILL       = 3'd2;
	localparam logic [2:0] OUT_FLUSH_WB   = 3'd3;
	localparam logic [2:0] OUT_FLUSH_DONE = 3'd4;
	localparam logic [2:0] OUT_DONE       = 3'd5;

	localparam logic [13:0] TOTAL_MAX = 14'd16383;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] lba;
		logic [31:0] range_start;
		logic [31:0] range_end;
		logic        flush_meta;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] block_lba;
		logic [3:0]  sector_count;
		logic [9:0]  slot_index;
		logic [21:0] buffer_offset;
		logic [13:0] flushed_sectors;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic       capture;
		logic [1:0] addr_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       ptr_inc;
		logic       flush_hit;
		logic       flush_end;
		logic       cnt_inc;
		logic       out_load;
		logic [2:0] out_sel;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       hit;
		logic       victim_dirty;
		logic       match;
		logic       ptr_end;
		logic       cnt_last;
		logic       out_free;
	} dp_stat_t;

endpackage

[rtl/direct_mapped_writeback_sector_cache_top.sv]
// Top level of the direct-mapped write-back sector cache directory controller.
// One request item is handled at a time; each slot entry (tag, valid, dirty, meta)
// lives in one single-port RAM with registered read, so every directory lookup reads
// the RAM before the check. An access passes capture, dispatch, read and check, then
// emits its results: location on a hit; fill, location on a clean miss; victim, fill,
// location on a dirty miss. A flush step reads and checks slots from the kept scan
// pointer until one matches, or reports the total when none is left; a discard sweeps
// the whole directory, reading and writing each slot. A result that cannot enter
// the output register holds the controller. Result items leave through an output
// register, so the next request is taken while the last result still waits. After
// reset a clearing pass zeroes every slot entry before the first request is accepted.
module direct_mapped_writeback_sector_cache_top
	import dmwsc_pkg::*;
#(
	parameter int NUM_SLOTS         = 1024,
	parameter int SECTORS_PER_BLOCK = 8,
	parameter int SECTOR_BYTES      = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy;

	dmwsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.busy      (busy),
		.stat      (stat),
		.cmd       (cmd)
	);

	dmwsc_dp #(
		.NUM_SLOTS         (NUM_SLOTS),
		.SECTORS_PER_BLOCK (SECTORS_PER_BLOCK),
		.SECTOR_BYTES      (SECTOR_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign req_stall = busy;

endmodule

[rtl/dmwsc_ram.sv]
// Generic single-port RAM with registered read.
module dmwsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     wr_en,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end

endmodule

[rtl/dmwsc_ctrl.sv]
// Controller state machine sequencing accesses, flush steps, discard and the clearing pass.
module dmwsc_ctrl
	import dmwsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_A_RD  = 4'd3;
	localparam logic [3:0] S_A_CHK = 4'd4;
	localparam logic [3:0] S_A_FIL = 4'd5;
	localparam logic [3:0] S_A_LOC = 4'd6;
	localparam logic [3:0] S_F_RD  = 4'd7;
	localparam logic [3:0] S_F_CHK = 4'd8;
	localparam logic [3:0] S_D_RD  = 4'd9;
	localparam logic [3:0] S_D_WR  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.addr_sel = ADDR_CNT;
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_ZERO;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op == OP_READ || stat.op == OP_WRITE || stat.op == OP_META) begin
					state_d = S_A_RD;
				end else if (stat.op == OP_FLUSH) begin
					state_d = S_F_RD;
				end else if (stat.op == OP_DISCARD) begin
					state_d = S_D_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_A_RD: begin
				cmd.addr_sel = ADDR_SLOT;
				state_d      = S_A_CHK;
			end
			S_A_CHK: begin
				cmd.addr_sel = ADDR_SLOT;
				if (stat.out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_sel   = WR_ACCESS;
					cmd.out_load = 1'b1;
					if (stat.hit) begin
						cmd.out_sel  = OUT_LOC;
						cmd.out_last = 1'b1;
						state_d      = S_IDLE;
					end else if (stat.victim_dirty) begin
						cmd.out_sel = OUT_VICTIM;
						state_d     = S_A_FIL;
					end else begin
						cmd.out_sel = OUT_FILL;
						state_d     = S_A_LOC;
					end
				end
			end
			S_A_FIL: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_FILL;
					state_d      = S_A_LOC;
				end
			end
			S_A_LOC: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_LOC;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_F_RD: begin
				cmd.addr_sel = ADDR_PTR;
				if (stat.ptr_end) begin
					if (stat.out_free) begin
						cmd.out_load  = 1'b1;
						cmd.out_sel   = OUT_FLUSH_DONE;
						cmd.out_last  = 1'b1;
						cmd.flush_end = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				cmd.addr_sel = ADDR_PTR;
				if (stat.match) begin
					if (stat.out_free) begin
						cmd.wr_en     = 1'b1;
						cmd.wr_sel    = WR_FLUSH;
						cmd.out_load  = 1'b1;
						cmd.out_sel   = OUT_FLUSH_WB;
						cmd.out_last  = 1'b1;
						cmd.flush_hit = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_F_RD;
				end
			end
			S_D_RD: begin
				cmd.addr_sel = ADDR_CNT;
				state_d      = S_D_WR;
			end
			S_D_WR: begin
				cmd.addr_sel = ADDR_CNT;
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_DISCARD;
				cmd.cnt_inc  = 1'b1;
				state_d      = stat.cnt_last ? S_DONE : S_D_RD;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OUT_DONE;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[rtl/dmwsc_dp.sv]
// Datapath: item registers, slot directory RAM, scan pointer, flush total and result register.
module dmwsc_dp
	import dmwsc_pkg::*;
#(
	parameter int NUM_SLOTS         = 1024,
	parameter int SECTORS_PER_BLOCK = 8,
	parameter int SECTOR_BYTES      = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int     IDX_W     = $clog2(NUM_SLOTS);
	localparam int     PTR_W     = $clog2(NUM_SLOTS + 1);
	localparam longint TAG_MAX   = 64'hFFFF_FFFF / SECTORS_PER_BLOCK;
	localparam int     TAG_W     = $clog2(TAG_MAX + 1);
	localparam int     SUB_W     = (SECTORS_PER_BLOCK > 1) ? $clog2(SECTORS_PER_BLOCK) : 1;
	localparam int     ENT_W     = TAG_W + 3;
	localparam int     BLK_BYTES = SECTORS_PER_BLOCK * SECTOR_BYTES;

	logic [2:0]       op_q;
	logic [TAG_W-1:0] tag_q;
	logic [SUB_W-1:0] sub_q;
	logic [TAG_W:0]   lo_q, hi_q;
	logic             cls_q;
	logic [PTR_W-1:0] ptr_q;
	logic [13:0]      total_q;
	logic [IDX_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] addr;
	logic [ENT_W-1:0] wr_data, rd_data;
	logic [TAG_W-1:0] ent_tag;
	logic             ent_valid, ent_dirty, ent_meta;
	logic             new_dirty, new_meta;
	logic [14:0]      total_sum;
	rsp_item_t        rsp_d;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req.opcode;
			tag_q <= TAG_W'(req.lba / SECTORS_PER_BLOCK);
			sub_q <= SUB_W'(req.lba % SECTORS_PER_BLOCK);
			lo_q  <= (TAG_W + 1)'((33'(req.range_start) + 33'(SECTORS_PER_BLOCK - 1))
				/ SECTORS_PER_BLOCK);
			hi_q  <= (TAG_W + 1)'((33'(req.range_end) + 33'(SECTORS_PER_BLOCK - 1))
				/ SECTORS_PER_BLOCK);
			cls_q <= req.flush_meta;
		end
	end

	assign slot = IDX_W'(tag_q % NUM_SLOTS);

	always_comb begin
		case (cmd.addr_sel)
			ADDR_SLOT: addr = slot;
			ADDR_PTR:  addr = ptr_q[IDX_W-1:0];
			ADDR_CNT:  addr = cnt_q;
			default:   addr = slot;
		endcase
	end

	assign ent_tag   = rd_data[TAG_W-1:0];
	assign ent_valid = rd_data[TAG_W];
	assign ent_dirty = rd_data[TAG_W+1];
	assign ent_meta  = rd_data[TAG_W+2];

	assign stat.op           = op_q;
	assign stat.hit          = ent_valid && (ent_tag == tag_q);
	assign stat.victim_dirty = ent_valid && ent_dirty;
	assign stat.match        = ent_valid && ent_dirty && (ent_meta == cls_q)
		&& ({1'b0, ent_tag} >= lo_q) && ({1'b0, ent_tag} < hi_q);
	assign stat.ptr_end      = (ptr_q == PTR_W'(NUM_SLOTS));
	assign stat.cnt_last     = (cnt_q == IDX_W'(NUM_SLOTS - 1));
	assign stat.out_free     = !rsp_valid_q || !rsp_stall;

	assign new_meta  = (stat.hit && ent_meta) || (op_q == OP_META);
	assign new_dirty = (stat.hit && ent_dirty) || (op_q != OP_READ);

	always_comb begin
		case (cmd.wr_sel)
			WR_ACCESS:  wr_data = {new_meta, new_dirty, 1'b1, tag_q};
			WR_FLUSH:   wr_data = {ent_meta, 1'b0, ent_valid, ent_tag};
			WR_DISCARD: wr_data = {2'b00, ent_valid, ent_tag};
			WR_ZERO:    wr_data = '0;
			default:    wr_data = '0;
		endcase
	end

	dmwsc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SLOTS)
	) u_dir (
		.clk     (clk),
		.addr    (addr),
		.wr_en   (cmd.wr_en),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign total_sum = 15'(total_q) + 15'(SECTORS_PER_BLOCK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			total_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.flush_end) begin
				ptr_q   <= '0;
				total_q <= '0;
			end else if (cmd.flush_hit) begin
				ptr_q   <= ptr_q + 1'b1;
				total_q <= (total_sum > 15'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[13:0];
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= stat.cnt_last ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		rsp_d      = '0;
		rsp_d.last = cmd.out_last;
		case (cmd.out_sel)
			OUT_LOC: begin
				rsp_d.kind          = KIND_LOC;
				rsp_d.slot_index    = 10'(slot);
				rsp_d.buffer_offset = 22'(slot * BLK_BYTES + sub_q * SECTOR_BYTES);
			end
			OUT_VICTIM: begin
				rsp_d.kind         = KIND_WB;
				rsp_d.block_lba    = 32'(ent_tag * SECTORS_PER_BLOCK);
				rsp_d.sector_count = 4'(SECTORS_PER_BLOCK);
				rsp_d.slot_index   = 10'(slot);
			end
			OUT_FILL: begin
				rsp_d.kind         = KIND_FILL;
				rsp_d.block_lba    = 32'(tag_q * SECTORS_PER_BLOCK);
				rsp_d.sector_count = 4'(SECTORS_PER_BLOCK);
				rsp_d.slot_index   = 10'(slot);
			end
			OUT_FLUSH_WB: begin
				rsp_d.kind         = KIND_WB;
				rsp_d.block_lba    = 32'(ent_tag * SECTORS_PER_BLOCK);
				rsp_d.sector_count = 4'(SECTORS_PER_BLOCK);
				rsp_d.slot_index   = 10'(ptr_q[IDX_W-1:0]);
			end
			OUT_FLUSH_DONE: begin
				rsp_d.kind            = KIND_DONE;
				rsp_d.flushed_sectors = total_q;
			end
			OUT_DONE: begin
				rsp_d.kind = KIND_DONE;
			end
			default: begin
				rsp_d.kind = KIND_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
